[rtl/fcl_pkg.sv]
// fcl_pkg: beat types, register map constants and carrier/level helpers
// for the fm carrier level write filter; no dependencies
package fcl_pkg;

    // host side beat
    typedef struct packed {
        logic       bank;
        logic       is_data;
        logic       is_write;
        logic [7:0] value;
    } in_beat_t;

    // chip side beat
    typedef struct packed {
        logic       out_bank;
        logic       out_is_data;
        logic       out_is_read;
        logic [7:0] out_value;
        logic       last;
    } out_beat_t;

    // level store access port
    typedef struct packed {
        logic       we;
        logic [5:0] waddr;
        logic [7:0] wdata;
        logic [5:0] raddr;
    } lvl_req_t;

    localparam int unsigned NUM_SLOTS = 44;
    localparam int unsigned NUM_CHANS = 18;

    // register map
    localparam logic [7:0] REG_LEVEL_FIRST = 8'h40;
    localparam logic [7:0] REG_LEVEL_LAST  = 8'h55;
    localparam logic [7:0] REG_CONN_FIRST  = 8'hC0;
    localparam logic [7:0] REG_CONN_LAST   = 8'hC8;
    localparam logic [7:0] REG_RHYTHM      = 8'hBD;
    localparam logic [7:0] REG_FOUR_OP     = 8'h04;
    localparam logic [4:0] LAST_OP         = 5'h15;
    localparam logic [5:0] LEVEL_MAX       = 6'h3F;

    // first operator of each channel within a bank
    localparam logic [4:0] FIRST_OP [9] = '{
        5'h00, 5'h01, 5'h02, 5'h08, 5'h09, 5'h0A, 5'h10, 5'h11, 5'h12
    };

    // level store slot of an operator
    function automatic logic [5:0] slot_of(logic bank, logic [4:0] op);
        return 6'(op) + (bank ? 6'd22 : 6'd0);
    endfunction

    // carrier decision from the shadowed mode state
    function automatic logic is_carrier(logic bank, logic [4:0] op, logic rhythm,
                                        logic [5:0] four_op, logic [17:0] conn);
        logic [2:0] pos;
        logic [3:0] ch;
        logic       second;
        logic [1:0] pair;
        logic [4:0] base;
        logic [2:0] fidx;
        logic       c1;
        logic       c2;
        logic       res;
        pos    = op[2:0];
        second = (pos >= 3'd3);
        ch     = 4'(op[4:3]) * 4'd3 + 4'(second ? pos - 3'd3 : pos);
        base   = bank ? 5'd9 : 5'd0;
        pair   = (ch < 4'd3) ? ch[1:0] : 2'(ch - 4'd3);
        fidx   = 3'(pair) + (bank ? 3'd3 : 3'd0);
        res    = 1'b0;
        if (op > LAST_OP || pos >= 3'd6)
        begin
            res = 1'b0;
        end
        else if (!bank && rhythm && ch >= 4'd7)
        begin
            res = 1'b1;
        end
        else if (ch < 4'd6 && four_op[fidx])
        begin
            c1 = conn[base + 5'(pair)];
            c2 = conn[base + 5'(pair) + 5'd3];
            if (ch >= 4'd3)
            begin
                res = second ? 1'b1 : (c1 & c2);
            end
            else
            begin
                res = second ? c2 : c1;
            end
        end
        else if (second)
        begin
            res = 1'b1;
        end
        else
        begin
            res = conn[base + 5'(ch)];
        end
        return res;
    endfunction

    // carrier level attenuation, scaling bits kept
    function automatic logic [7:0] scale_level(logic [7:0] v, logic [5:0] steps,
                                               logic carrier);
        logic [6:0] tl;
        tl = 7'(v[5:0]) + 7'(steps);
        if (steps == 6'd0 || !carrier)
        begin
            return v;
        end
        if (tl > 7'(LEVEL_MAX))
        begin
            tl = 7'(LEVEL_MAX);
        end
        return {v[7:6], tl[5:0]};
    endfunction

endpackage

[rtl/fm_carrier_level_write_filter_unit.sv]
// fm_carrier_level_write_filter_unit: shadow state, beat handling and the
// level re-send sequencer; uses fcl_pkg and fcl_level_store
//
// Usage
// - host beats arrive on in_valid/in_stall/in_data, chip accesses leave on
//   out_valid/out_stall/out_data; a beat moves when valid is high and stall low
// - cfg_we/cfg_data write the carrier attenuation step count while idle
// - the first chip access of a host beat is shown in the cycle after the beat
//   is taken, from the output register
// - throughput: reads, address writes and data writes that do not change a
//   connection bit make one access each, one beat per cycle when not stalled
// - a connection bit change makes 3 to 11 accesses: the forwarded write, two
//   accesses per stored level re-sent (none for an operator with no stored
//   level, up to four operators), then the two address latch restores; the
//   input is held in stall until the restore of bank 1 has been issued
// - when out_stall is high the output register holds its beat, the sequencer
//   waits to issue its next access and the input waits
// - reset clears the shadow registers, the attenuation and all seen bits;
//   no clearing pass is needed, the block takes beats right after reset
module fm_carrier_level_write_filter_unit
    import fcl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [5:0] cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_RS_ADDR  = 5'b00010,
        ST_RS_DATA  = 5'b00100,
        ST_RESTORE0 = 5'b01000,
        ST_RESTORE1 = 5'b10000
    } seq_state_t;

    // shadow state
    logic [5:0]  steps_reg;
    logic [7:0]  latch_reg [2];
    logic        rhythm_reg;
    logic [5:0]  four_op_reg;
    logic [17:0] conn_reg;

    // sequencer
    seq_state_t  state_reg, state_next;
    logic        seq_bank_reg;
    logic [4:0]  op_a_reg, op_b_reg;
    logic [1:0]  k_reg, k_next;
    logic        partner_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_beat_reg;

    // level store
    lvl_req_t    lvl_req;
    logic [7:0]  rd_level;
    logic        rd_seen;

    logic        out_ok;
    logic        in_fire;
    logic        emit;
    out_beat_t   emit_beat;
    logic        from_seq;

    logic [7:0]  reg_cur;
    logic        is_lvl;
    logic [4:0]  lvl_op;
    logic        is_conn;
    logic [3:0]  conn_ch;
    logic [4:0]  conn_idx;
    logic        conn_chg;
    logic [1:0]  pair_c;
    logic        has_partner;
    logic [3:0]  partner_ch;
    out_beat_t   direct_beat;

    logic [4:0]  cur_op;
    logic        last_step;
    logic [7:0]  rs_level;

    // handshake
    assign out_ok   = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_ok;
    assign in_fire  = in_valid && !in_stall;

    // decode of the incoming beat against the latched register
    always_comb
    begin
        reg_cur     = latch_reg[in_data.bank];
        is_lvl      = (reg_cur >= REG_LEVEL_FIRST) && (reg_cur <= REG_LEVEL_LAST);
        lvl_op      = 5'(reg_cur - REG_LEVEL_FIRST);
        is_conn     = (reg_cur >= REG_CONN_FIRST) && (reg_cur <= REG_CONN_LAST);
        conn_ch     = 4'(reg_cur - REG_CONN_FIRST);
        conn_idx    = (in_data.bank ? 5'd9 : 5'd0) + 5'(conn_ch);
        conn_chg    = is_conn && (conn_reg[conn_idx] != in_data.value[0]);
        pair_c      = (conn_ch < 4'd3) ? conn_ch[1:0] : 2'(conn_ch - 4'd3);
        has_partner = (conn_ch < 4'd6)
                      && four_op_reg[3'(pair_c) + (in_data.bank ? 3'd3 : 3'd0)];
        partner_ch  = (conn_ch < 4'd3) ? conn_ch + 4'd3 : conn_ch - 4'd3;

        direct_beat.out_bank    = in_data.bank;
        direct_beat.out_is_data = in_data.is_data;
        direct_beat.out_is_read = 1'b0;
        direct_beat.out_value   = in_data.value;
        direct_beat.last        = 1'b1;
        if (!in_data.is_write)
        begin
            direct_beat.out_is_read = 1'b1;
            direct_beat.out_value   = 8'h00;
        end
        else if (in_data.is_data && is_lvl)
        begin
            direct_beat.out_value = scale_level(in_data.value, steps_reg,
                is_carrier(in_data.bank, lvl_op, rhythm_reg, four_op_reg, conn_reg));
        end
        else if (in_data.is_data)
        begin
            direct_beat.last = !conn_chg;
        end
    end

    // shadow register updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg    <= '0;
            latch_reg[0] <= '0;
            latch_reg[1] <= '0;
            rhythm_reg   <= 1'b0;
            four_op_reg  <= '0;
            conn_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                steps_reg <= cfg_data;
            end
            if (in_fire && in_data.is_write && !in_data.is_data)
            begin
                latch_reg[in_data.bank] <= in_data.value;
            end
            if (in_fire && in_data.is_write && in_data.is_data)
            begin
                if (is_conn)
                begin
                    conn_reg[conn_idx] <= in_data.value[0];
                end
                if (reg_cur == REG_RHYTHM && !in_data.bank)
                begin
                    rhythm_reg <= in_data.value[5];
                end
                if (reg_cur == REG_FOUR_OP && in_data.bank)
                begin
                    four_op_reg <= in_data.value[5:0];
                end
            end
        end
    end

    // operator being re-sent
    assign cur_op    = (k_reg[1] ? op_b_reg : op_a_reg) + (k_reg[0] ? 5'd3 : 5'd0);
    assign last_step = (k_reg == (partner_reg ? 2'd3 : 2'd1));
    assign rs_level  = scale_level(rd_level, steps_reg,
        is_carrier(seq_bank_reg, cur_op, rhythm_reg, four_op_reg, conn_reg));

    // level store port: written by level data beats, read at the re-send slot
    always_comb
    begin
        lvl_req.we    = in_fire && in_data.is_write && in_data.is_data && is_lvl;
        lvl_req.waddr = slot_of(in_data.bank, lvl_op);
        lvl_req.wdata = in_data.value;
        lvl_req.raddr = slot_of(seq_bank_reg, cur_op);
    end

    fcl_level_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (lvl_req),
        .rd_level (rd_level),
        .rd_seen  (rd_seen)
    );

    // re-send sequencer
    always_comb
    begin
        state_next          = state_reg;
        k_next              = k_reg;
        from_seq            = 1'b0;
        emit_beat.out_bank    = seq_bank_reg;
        emit_beat.out_is_data = 1'b0;
        emit_beat.out_is_read = 1'b0;
        emit_beat.out_value   = 8'h00;
        emit_beat.last        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_data.is_write && in_data.is_data && conn_chg)
                begin
                    state_next = ST_RS_ADDR;
                    k_next     = 2'd0;
                end
            end
            ST_RS_ADDR:
            begin
                if (!rd_seen)
                begin
                    state_next = last_step ? ST_RESTORE0 : ST_RS_ADDR;
                    k_next     = k_reg + 2'd1;
                end
                else if (out_ok)
                begin
                    from_seq            = 1'b1;
                    emit_beat.out_value = REG_LEVEL_FIRST + 8'(cur_op);
                    state_next          = ST_RS_DATA;
                end
            end
            ST_RS_DATA:
            begin
                if (out_ok)
                begin
                    from_seq              = 1'b1;
                    emit_beat.out_is_data = 1'b1;
                    emit_beat.out_value   = rs_level;
                    state_next            = last_step ? ST_RESTORE0 : ST_RS_ADDR;
                    k_next                = k_reg + 2'd1;
                end
            end
            ST_RESTORE0:
            begin
                if (out_ok)
                begin
                    from_seq            = 1'b1;
                    emit_beat.out_bank  = 1'b0;
                    emit_beat.out_value = latch_reg[0];
                    state_next          = ST_RESTORE1;
                end
            end
            ST_RESTORE1:
            begin
                if (out_ok)
                begin
                    from_seq            = 1'b1;
                    emit_beat.out_bank  = 1'b1;
                    emit_beat.out_value = latch_reg[1];
                    emit_beat.last      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            seq_bank_reg <= 1'b0;
            op_a_reg     <= '0;
            op_b_reg     <= '0;
            partner_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (in_fire)
            begin
                seq_bank_reg <= in_data.bank;
                op_a_reg     <= FIRST_OP[conn_ch];
                op_b_reg     <= FIRST_OP[partner_ch];
                partner_reg  <= has_partner;
            end
        end
    end

    // output register
    assign emit = in_fire || from_seq;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_beat_reg <= from_seq ? emit_beat : direct_beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

endmodule

[rtl/fcl_level_store.sv]
// fcl_level_store: stored total levels per operator slot in a synchronous
// memory, plus per-slot seen bits; uses fcl_pkg
module fcl_level_store
    import fcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lvl_req_t   req,
    output logic [7:0] rd_level,
    output logic       rd_seen
);

    logic [7:0]           level_mem [NUM_SLOTS];
    logic [7:0]           rd_level_reg;
    logic [NUM_SLOTS-1:0] seen_reg;

    // level memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            level_mem[req.waddr] <= req.wdata;
        end
        rd_level_reg <= level_mem[req.raddr];
    end

    // seen bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (req.we)
        begin
            seen_reg[req.waddr] <= 1'b1;
        end
    end

    assign rd_level = rd_level_reg;
    assign rd_seen  = seen_reg[req.raddr];

endmodule

[rtl/fcl_checker.sv]
// fcl_checker: port level checks of the fm carrier level write filter,
// bound to the top level; uses fcl_pkg
module fcl_checker
    import fcl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cfg_we,
    input logic [5:0] cfg_data,
    input logic      in_valid,
    input logic      in_stall,
    input in_beat_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_data
);

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    // a host read is forwarded at once as a single read beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !in_data.is_write |=>
            out_valid && out_data.out_is_read && out_data.last
            && out_data.out_value == 8'h00 && out_data.out_bank == $past(in_data.bank))
        else $error("host read not forwarded as one read beat");

    // an address write is passed through unchanged as the only beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.is_write && !in_data.is_data |=>
            out_valid && !out_data.out_is_data && !out_data.out_is_read
            && out_data.last && out_data.out_value == $past(in_data.value))
        else $error("address write not passed through");

    // reads are never part of a multi-beat sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_is_read |-> out_data.last)
        else $error("read beat not marked last");

endmodule

bind fm_carrier_level_write_filter_unit fcl_checker u_fcl_checker (.*);

[test/fcl_level_filter_checker.sv]
// fcl_level_filter_checker: watches the host and chip channels of the fm carrier
// level write filter, predicts every chip access and compares; uses fcl_pkg
module fcl_level_filter_checker
    import fcl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [5:0] cfg_data,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_beat_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_beat_t out_data,
    output int        fail_count,
    output int        pending,
    output int        checked_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPS_PER_BANK   = 22;
    localparam int CHANS_PER_BANK = 9;
    localparam int SLOT_HOLE      = 6;
    localparam int MAX_REPORTS    = 10;

    // shadow of the chip mode state
    logic [5:0]  atten_steps;
    logic [7:0]  latch_reg [2];
    logic        rhythm_on;
    logic [5:0]  four_op_en;
    logic [17:0] conn_bit;
    logic [7:0]  level_mem [2*OPS_PER_BANK];
    logic        level_valid [2*OPS_PER_BANK];

    out_beat_t expected_access_q [$];
    out_beat_t access_batch [$];

    // carrier decision for one operator of a bank
    function automatic logic carrier_op(logic bk, int op);
        int   slot_pos;
        int   chan;
        int   pair;
        int   cbase;
        logic upper;
        logic c1;
        logic c2;
        if (op >= OPS_PER_BANK)
            return 1'b0;
        slot_pos = op % 8;
        if (slot_pos >= SLOT_HOLE)
            return 1'b0;
        chan  = (op / 8) * 3 + slot_pos % 3;
        upper = (slot_pos >= 3);
        cbase = bk ? CHANS_PER_BANK : 0;
        if (!bk && rhythm_on && chan >= 7)
            return 1'b1;
        if (chan < 6)
        begin
            pair = chan % 3;
            if (four_op_en[pair + (bk ? 3 : 0)])
            begin
                c1 = conn_bit[cbase + pair];
                c2 = conn_bit[cbase + pair + 3];
                if (chan >= 3)
                    return upper ? 1'b1 : (c1 & c2);
                return upper ? c2 : c1;
            end
        end
        if (upper)
            return 1'b1;
        return conn_bit[cbase + chan];
    endfunction

    // carrier levels get the step count added, saturating, scaling bits kept
    function automatic logic [7:0] attenuate(logic bk, int op, logic [7:0] v);
        int lvl;
        if (atten_steps == 6'd0 || !carrier_op(bk, op))
            return v;
        lvl = v[5:0] + atten_steps;
        if (lvl > LEVEL_MAX)
            lvl = LEVEL_MAX;
        return {v[7:6], 6'(lvl)};
    endfunction

    task automatic add_access(logic bk, logic dat, logic rd, logic [7:0] v);
        out_beat_t a;
        a.out_bank    = bk;
        a.out_is_data = dat;
        a.out_is_read = rd;
        a.out_value   = v;
        a.last        = 1'b0;
        access_batch.push_back(a);
    endtask

    // address/data pair re-sending one stored level, skipped if never written
    task automatic add_level_resend(logic bk, int op);
        int slot;
        slot = (bk ? OPS_PER_BANK : 0) + op;
        if (!level_valid[slot])
            return;
        add_access(bk, 1'b0, 1'b0, REG_LEVEL_FIRST + 8'(op));
        add_access(bk, 1'b1, 1'b0, attenuate(bk, op, level_mem[slot]));
    endtask

    // chip accesses caused by one host beat, last flag on the final one
    task automatic predict_host_beat(in_beat_t b);
        int        regno;
        int        op;
        int        slot;
        int        ch;
        int        cidx;
        int        pair;
        int        partner;
        out_beat_t a;
        access_batch.delete();
        regno = int'(latch_reg[b.bank]);
        if (!b.is_write)
        begin
            add_access(b.bank, b.is_data, 1'b1, 8'h00);
        end
        else if (!b.is_data)
        begin
            latch_reg[b.bank] = b.value;
            add_access(b.bank, 1'b0, 1'b0, b.value);
        end
        else if (regno >= REG_LEVEL_FIRST && regno <= REG_LEVEL_LAST)
        begin
            op   = regno - int'(REG_LEVEL_FIRST);
            slot = (b.bank ? OPS_PER_BANK : 0) + op;
            level_mem[slot]   = b.value;
            level_valid[slot] = 1'b1;
            add_access(b.bank, 1'b1, 1'b0, attenuate(b.bank, op, b.value));
        end
        else if (regno >= REG_CONN_FIRST && regno <= REG_CONN_LAST)
        begin
            ch   = regno - int'(REG_CONN_FIRST);
            cidx = (b.bank ? CHANS_PER_BANK : 0) + ch;
            add_access(b.bank, 1'b1, 1'b0, b.value);
            if (conn_bit[cidx] != b.value[0])
            begin
                conn_bit[cidx] = b.value[0];
                add_level_resend(b.bank, int'(FIRST_OP[ch]));
                add_level_resend(b.bank, int'(FIRST_OP[ch]) + 3);
                if (ch < 6)
                begin
                    pair    = ch % 3;
                    partner = (ch < 3) ? ch + 3 : ch - 3;
                    if (four_op_en[pair + (b.bank ? 3 : 0)])
                    begin
                        add_level_resend(b.bank, int'(FIRST_OP[partner]));
                        add_level_resend(b.bank, int'(FIRST_OP[partner]) + 3);
                    end
                end
                // both address latches restored after the re-send
                add_access(1'b0, 1'b0, 1'b0, latch_reg[0]);
                add_access(1'b1, 1'b0, 1'b0, latch_reg[1]);
            end
        end
        else
        begin
            if (regno == REG_RHYTHM && !b.bank)
                rhythm_on = b.value[5];
            if (regno == REG_FOUR_OP && b.bank)
                four_op_en = b.value[5:0];
            add_access(b.bank, 1'b1, 1'b0, b.value);
        end
        foreach (access_batch[i])
        begin
            a      = access_batch[i];
            a.last = (i == access_batch.size() - 1);
            expected_access_q.push_back(a);
        end
    endtask

    // compare chip beats, then predict from host beats
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t exp_beat;
        if (!rst_n)
        begin
            atten_steps = '0;
            latch_reg   = '{default: '0};
            rhythm_on   = 1'b0;
            four_op_en  = '0;
            conn_bit    = '0;
            level_mem   = '{default: '0};
            level_valid = '{default: 1'b0};
            expected_access_q.delete();
            fail_count    = 0;
            pending       = 0;
            checked_count = 0;
        end
        else
        begin
            if (cfg_we)
                atten_steps = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (expected_access_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: chip access with none expected: bank %0d data %0d rd %0d value %02h last %0d",
                                 $realtime, out_data.out_bank, out_data.out_is_data,
                                 out_data.out_is_read, out_data.out_value, out_data.last);
                    fail_count++;
                end
                else
                begin
                    exp_beat = expected_access_q.pop_front();
                    checked_count++;
                    if (out_data.out_bank !== exp_beat.out_bank ||
                        out_data.out_is_data !== exp_beat.out_is_data ||
                        out_data.out_is_read !== exp_beat.out_is_read ||
                        out_data.out_value !== exp_beat.out_value ||
                        out_data.last !== exp_beat.last)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display("%0t: chip access mismatch: exp bank %0d data %0d rd %0d value %02h last %0d, got bank %0d data %0d rd %0d value %02h last %0d",
                                     $realtime, exp_beat.out_bank, exp_beat.out_is_data,
                                     exp_beat.out_is_read, exp_beat.out_value, exp_beat.last,
                                     out_data.out_bank, out_data.out_is_data,
                                     out_data.out_is_read, out_data.out_value, out_data.last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_host_beat(in_data);
            pending = expected_access_q.size();
        end
    end

endmodule

[test/fm_carrier_level_write_filter_unit_tb.sv]
// fm_carrier_level_write_filter_unit_tb: clock, reset, host beats, chip side
// stalls and the verdict; uses fcl_pkg, fcl_level_filter_checker and the block
module fm_carrier_level_write_filter_unit_tb;

    import fcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_BEATS = 40;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [5:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;

    int fail_count;
    int pending;
    int checked_count;
    int beats_sent;
    int settings_used;
    bit quiet_phase;

    fm_carrier_level_write_filter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    fcl_level_filter_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // chip side stall, drawn per accepted beat
    initial
    begin
        int gap;
        out_stall = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            gap = quiet_phase ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // one host beat, entered and left at a falling edge
    task automatic send_beat(logic bk, logic dat, logic wr, logic [7:0] v);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         = 1'b1;
        in_data.bank     = bk;
        in_data.is_data  = dat;
        in_data.is_write = wr;
        in_data.value    = v;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic write_reg(logic bk, logic [7:0] regno, logic [7:0] v);
        send_beat(bk, 1'b0, 1'b1, regno);
        send_beat(bk, 1'b1, 1'b1, v);
    endtask

    // step count written only once every access has drained
    task automatic set_level_steps(logic [5:0] steps);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = steps;
        @(negedge clk);
        cfg_we = 1'b0;
        settings_used++;
    endtask

    // mostly address/data pairs aimed at the interesting registers, some noise
    task automatic random_sequence();
        int         kind;
        int         pick;
        logic       bk;
        logic [7:0] regno;
        kind = $urandom_range(0, 9);
        bk   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            regno = REG_LEVEL_FIRST + 8'($urandom_range(0, 21));
        else if (pick <= 6)
            regno = REG_CONN_FIRST + 8'($urandom_range(0, 8));
        else if (pick == 7)
            regno = REG_RHYTHM;
        else if (pick == 8)
            regno = REG_FOUR_OP;
        else
            regno = 8'($urandom_range(0, 255));
        if (kind == 0)
            send_beat(bk, 1'($urandom_range(0, 1)), 1'b0, 8'($urandom_range(0, 255)));
        else if (kind == 1)
            send_beat(bk, 1'($urandom_range(0, 1)), 1'b1, 8'($urandom_range(0, 255)));
        else
        begin
            write_reg(bk, regno, 8'($urandom_range(0, 255)));
            // repeated data beat on the same latch
            if ($urandom_range(0, 5) == 0)
                send_beat(bk, 1'b1, 1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_phase(logic [5:0] steps, bit quiet);
        int start;
        set_level_steps(steps);
        quiet_phase = quiet;
        start       = beats_sent;
        while (beats_sent - start < PHASE_BEATS)
            random_sequence();
        quiet_phase = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        beats_sent    = 0;
        settings_used = 0;
        quiet_phase   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reads, saturation, hole, rhythm, four-op re-send
        set_level_steps(6'd5);
        send_beat(1'b0, 1'b0, 1'b0, 8'hFF);
        send_beat(1'b1, 1'b1, 1'b0, 8'h00);
        write_reg(1'b0, REG_LEVEL_FIRST + 8'h03, 8'hFF);
        write_reg(1'b0, REG_LEVEL_FIRST + 8'h06, 8'h00);
        write_reg(1'b0, REG_RHYTHM, 8'h20);
        write_reg(1'b0, REG_LEVEL_FIRST + 8'h11, 8'h3A);
        write_reg(1'b1, REG_FOUR_OP, 8'h3F);
        write_reg(1'b1, REG_LEVEL_FIRST + 8'h00, 8'h7F);
        write_reg(1'b1, REG_LEVEL_FIRST + 8'h03, 8'hC0);
        write_reg(1'b1, REG_LEVEL_FIRST + 8'h08, 8'h3E);
        write_reg(1'b1, REG_LEVEL_FIRST + 8'h0B, 8'h81);
        write_reg(1'b1, REG_CONN_FIRST, 8'h01);
        send_beat(1'b1, 1'b1, 1'b1, 8'h01);
        write_reg(1'b0, REG_CONN_FIRST + 8'h05, 8'hFF);

        // random phases across the step range
        random_phase(6'd63, 1'b0);
        random_phase(6'd0, 1'b1);
        random_phase(6'd1, 1'b0);
        random_phase(6'($urandom_range(2, 62)), 1'b0);
        random_phase(6'd32, 1'b0);

        // drain
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);

        $display("host beats sent: %0d, chip accesses checked: %0d, step settings: %0d",
                 beats_sent, checked_count, settings_used);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
